[rtl/core/assert_macros.svh]
// Assertion macros for the clipper RTL.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("clipper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("clipper assertion failed");

`endif

[rtl/core/hpc_pkg.sv]
// Types, codes and helper functions of the polygon plane clipper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hpc_pkg;

	typedef struct packed {
		logic signed [31:0] clip_x;
		logic signed [31:0] clip_y;
		logic signed [31:0] clip_z;
		logic signed [31:0] clip_w;
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic [47:0] color_rgb;
		logic last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_clip_x;
		logic signed [31:0] out_clip_y;
		logic signed [31:0] out_clip_z;
		logic signed [31:0] out_clip_w;
		logic signed [31:0] out_world_x;
		logic signed [31:0] out_world_y;
		logic signed [31:0] out_world_z;
		logic signed [31:0] out_tex_u;
		logic signed [31:0] out_tex_v;
		logic [47:0] out_color_rgb;
		logic vertex_valid;
		logic end_of_polygon;
	} out_item_t;

	localparam logic [2:0] PLANE_LEFT   = 3'd0;
	localparam logic [2:0] PLANE_RIGHT  = 3'd1;
	localparam logic [2:0] PLANE_BOTTOM = 3'd2;
	localparam logic [2:0] PLANE_TOP    = 3'd3;
	localparam logic [2:0] PLANE_NEAR   = 3'd4;
	localparam logic [2:0] PLANE_FAR    = 3'd5;

	// Edge codes: (first,prev), (prev,cur), closing (cur,first)
	localparam logic [1:0] EDGE_FP = 2'd0;
	localparam logic [1:0] EDGE_PC = 2'd1;
	localparam logic [1:0] EDGE_CF = 2'd2;

	localparam logic [3:0] FLD_LAST = 4'd11;

	typedef enum logic [1:0] {
		KIND_PASS  = 2'd0,
		KIND_ISECT = 2'd1,
		KIND_MARK  = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic capture;
		logic [1:0] edge_sel;
		logic div_start;
		logic do_mul;
		logic do_add;
		logic [3:0] fld;
		logic load_out;
		out_kind_t out_kind;
		logic out_eop;
		logic store_first;
		logic store_prev;
	} cmd_t;

	typedef struct packed {
		logic first_out;
		logic prev_out;
		logic cur_out;
		logic cur_last;
		logic div_busy;
		logic out_free;
	} sts_t;

	function automatic logic signed [32:0] hpc_dist(in_item_t v, logic [2:0] plane);
		logic signed [32:0] w;
		logic signed [32:0] d;
		w = 33'(v.clip_w);
		case (plane)
			PLANE_LEFT:   d = w + 33'(v.clip_x);
			PLANE_RIGHT:  d = w - 33'(v.clip_x);
			PLANE_BOTTOM: d = w + 33'(v.clip_y);
			PLANE_TOP:    d = w - 33'(v.clip_y);
			PLANE_NEAR:   d = w + 33'(v.clip_z);
			PLANE_FAR:    d = w - 33'(v.clip_z);
			default:      d = '0;
		endcase
		return d;
	endfunction

	// Field k as a signed 33-bit value: coordinates sign-extended, color zero-extended
	function automatic logic signed [32:0] hpc_field(in_item_t v, logic [3:0] k);
		logic signed [32:0] f;
		case (k)
			4'd0:    f = 33'(v.clip_x);
			4'd1:    f = 33'(v.clip_y);
			4'd2:    f = 33'(v.clip_z);
			4'd3:    f = 33'(v.clip_w);
			4'd4:    f = 33'(v.world_x);
			4'd5:    f = 33'(v.world_y);
			4'd6:    f = 33'(v.world_z);
			4'd7:    f = 33'(v.tex_u);
			4'd8:    f = 33'(v.tex_v);
			4'd9:    f = {17'd0, v.color_rgb[15:0]};
			4'd10:   f = {17'd0, v.color_rgb[31:16]};
			4'd11:   f = {17'd0, v.color_rgb[47:32]};
			default: f = '0;
		endcase
		return f;
	endfunction

	function automatic out_item_t hpc_to_out(in_item_t v, logic eop);
		out_item_t o;
		o.out_clip_x     = v.clip_x;
		o.out_clip_y     = v.clip_y;
		o.out_clip_z     = v.clip_z;
		o.out_clip_w     = v.clip_w;
		o.out_world_x    = v.world_x;
		o.out_world_y    = v.world_y;
		o.out_world_z    = v.world_z;
		o.out_tex_u      = v.tex_u;
		o.out_tex_v      = v.tex_v;
		o.out_color_rgb  = v.color_rgb;
		o.vertex_valid   = 1'b1;
		o.end_of_polygon = eop;
		return o;
	endfunction

	// End marker: all fields zero, end of polygon set
	function automatic out_item_t hpc_marker();
		out_item_t o;
		o = '0;
		o.end_of_polygon = 1'b1;
		return o;
	endfunction

endpackage

[rtl/core/hpc_div.sv]
// Restoring divider for the crossing parameter t = d0/(d0-d1), unsigned Q0.T.
// Depends on hpc_pkg.
`timescale 1ns / 1ps

module hpc_div import hpc_pkg::*; #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [32:0] d0,
	input  logic signed [32:0] d1,
	output logic busy,
	output logic [T_FRAC_BITS-1:0] t
);

	localparam int CW = $clog2(T_FRAC_BITS + 1);

	logic signed [33:0] den;
	logic [32:0] un;
	logic [33:0] ud;
	logic trivial;
	logic [34:0] r2;
	logic ge;

	logic [33:0] rem_q;
	logic [33:0] ud_q;
	logic [T_FRAC_BITS-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	assign den = 34'(d0) - 34'(d1);
	assign un  = d0[32] ? 33'(-d0) : 33'(d0);
	assign ud  = den[33] ? 34'(-den) : 34'(den);
	// zero denominator, zero numerator or negative ratio give t = 0
	assign trivial = (den == '0) || (d0 == '0) || (d0[32] != den[33]);
	assign r2 = {rem_q, 1'b0};
	assign ge = r2 >= {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !trivial && ({1'b0, un} < ud);
			cnt_q  <= CW'(T_FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 34'(un);
			ud_q  <= ud;
			if (trivial) begin
				q_q <= '0;
			end else if ({1'b0, un} >= ud) begin
				q_q <= '1;
			end else begin
				q_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? 34'(r2 - {1'b0, ud_q}) : r2[33:0];
			q_q   <= {q_q[T_FRAC_BITS-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign t    = q_q;

endmodule

[rtl/core/hpc_datapath.sv]
// Clipper datapath: held vertices, plane distances, shared lerp multiplier, output register.
// Depends on hpc_pkg and hpc_div.
`timescale 1ns / 1ps

module hpc_datapath import hpc_pkg::*; #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [2:0] plane,
	input  in_item_t vtx,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic res_ready,
	output logic res_valid,
	output out_item_t res
);

	localparam int PW = 35 + T_FRAC_BITS;

	in_item_t first_q, prev_q, cur_q, ix_q;
	logic first_out_q, prev_out_q, cur_out_q;
	in_item_t va, vb;
	logic signed [32:0] fa, fb;
	logic signed [33:0] diff;
	logic signed [T_FRAC_BITS:0] tsig;
	logic signed [PW-1:0] prod_q;
	logic signed [32:0] a_q;
	logic signed [PW-1:0] sum;
	logic [T_FRAC_BITS-1:0] t;
	logic div_busy;
	out_item_t res_q;
	logic res_valid_q;
	logic out_free;

	always_comb begin
		case (cmd.edge_sel)
			EDGE_FP: begin va = first_q; vb = prev_q; end
			EDGE_PC: begin va = prev_q;  vb = cur_q;  end
			EDGE_CF: begin va = cur_q;   vb = first_q; end
			default: begin va = first_q; vb = prev_q; end
		endcase
	end

	hpc_div #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.d0     (hpc_dist(va, plane)),
		.d1     (hpc_dist(vb, plane)),
		.busy   (div_busy),
		.t      (t)
	);

	assign fa   = hpc_field(va, cmd.fld);
	assign fb   = hpc_field(vb, cmd.fld);
	assign diff = 34'(fb) - 34'(fa);
	assign tsig = {1'b0, t};
	// floor((b-a)*t / 2^T) is an arithmetic shift
	assign sum  = PW'(a_q) + (prod_q >>> T_FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q     <= vtx;
			cur_out_q <= hpc_dist(vtx, plane) < 0;
		end
		if (cmd.store_first) begin
			first_q     <= cur_q;
			first_out_q <= cur_out_q;
		end
		if (cmd.store_prev) begin
			prev_q     <= cur_q;
			prev_out_q <= cur_out_q;
		end
		if (cmd.do_mul) begin
			prod_q <= diff * tsig;
			a_q    <= fa;
		end
		if (cmd.do_add) begin
			case (cmd.fld)
				4'd0:    ix_q.clip_x  <= sum[31:0];
				4'd1:    ix_q.clip_y  <= sum[31:0];
				4'd2:    ix_q.clip_z  <= sum[31:0];
				4'd3:    ix_q.clip_w  <= sum[31:0];
				4'd4:    ix_q.world_x <= sum[31:0];
				4'd5:    ix_q.world_y <= sum[31:0];
				4'd6:    ix_q.world_z <= sum[31:0];
				4'd7:    ix_q.tex_u   <= sum[31:0];
				4'd8:    ix_q.tex_v   <= sum[31:0];
				4'd9:    ix_q.color_rgb[15:0]  <= sum[15:0];
				4'd10:   ix_q.color_rgb[31:16] <= sum[15:0];
				4'd11:   ix_q.color_rgb[47:32] <= sum[15:0];
				default: ix_q.last_vertex <= 1'b0;
			endcase
		end
		if (cmd.load_out) begin
			case (cmd.out_kind)
				KIND_PASS:  res_q <= hpc_to_out(va, cmd.out_eop);
				KIND_ISECT: res_q <= hpc_to_out(ix_q, cmd.out_eop);
				default:    res_q <= hpc_marker();
			endcase
		end
	end

	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign sts.first_out = first_out_q;
	assign sts.prev_out  = prev_out_q;
	assign sts.cur_out   = cur_out_q;
	assign sts.cur_last  = cur_q.last_vertex;
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = out_free;

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/hpc_ctrl.sv]
// Clipper sequencer: plans the result slots of one vertex and steps the datapath.
// Depends on hpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpc_ctrl import hpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vtx_valid,
	output logic vtx_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PLAN = 9'b000000010,
		ST_SCAN = 9'b000000100,
		ST_DIV  = 9'b000001000,
		ST_MUL  = 9'b000010000,
		ST_ADD  = 9'b000100000,
		ST_EMIT = 9'b001000000,
		ST_MARK = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] count_q;
	logic [5:0] mask_q, mask_new, rest;
	logic [2:0] slot_q, lo;
	logic [3:0] fld_q;
	logic mark_q;
	logic e0, e1, e2;

	// slot 2e: pass the edge's start vertex, slot 2e+1: its crossing
	always_comb begin
		e0 = count_q == 2'd2;
		e1 = count_q[1];
		e2 = count_q[1] && sts.cur_last;
		mask_new[0] = e0 && !sts.first_out;
		mask_new[1] = e0 && (sts.first_out != sts.prev_out);
		mask_new[2] = e1 && !sts.prev_out;
		mask_new[3] = e1 && (sts.prev_out != sts.cur_out);
		mask_new[4] = e2 && !sts.cur_out;
		mask_new[5] = e2 && (sts.cur_out != sts.first_out);
	end

	always_comb begin
		lo = '0;
		for (int i = 5; i >= 0; i--) begin
			if (mask_q[i]) lo = 3'(i);
		end
	end

	assign rest = mask_q & ~(6'd1 << slot_q);

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.out_kind    = KIND_PASS;
		cmd.fld         = fld_q;
		cmd.edge_sel    = (state_q == ST_SCAN) ? lo[2:1] : slot_q[2:1];
		case (state_q)
			ST_IDLE: begin
				cmd.capture = vtx_valid;
				if (vtx_valid) state_d = ST_PLAN;
			end
			ST_PLAN: state_d = ST_SCAN;
			ST_SCAN: begin
				if (mask_q == '0) begin
					state_d = mark_q ? ST_MARK : ST_FIN;
				end else if (lo[0]) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.do_add = 1'b1;
				state_d = (fld_q == FLD_LAST) ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = slot_q[0] ? KIND_ISECT : KIND_PASS;
					cmd.out_eop  = sts.cur_last && (rest == '0);
					state_d = ST_SCAN;
				end
			end
			ST_MARK: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = KIND_MARK;
					cmd.out_eop  = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.store_first = count_q == 2'd0;
				cmd.store_prev  = count_q != 2'd0;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			mask_q  <= '0;
			slot_q  <= '0;
			fld_q   <= '0;
			mark_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PLAN) begin
				mask_q <= mask_new;
				mark_q <= sts.cur_last && (mask_new == '0);
			end
			if (state_q == ST_SCAN && mask_q != '0) slot_q <= lo;
			if (state_q == ST_DIV) fld_q <= '0;
			if (state_q == ST_ADD) fld_q <= fld_q + 1'b1;
			if (state_q == ST_EMIT && sts.out_free) mask_q <= rest;
			if (state_q == ST_FIN) begin
				if (sts.cur_last) count_q <= '0;
				else if (count_q != 2'd3) count_q <= count_q + 1'b1;
			end
		end
	end

	assign vtx_ready = state_q == ST_IDLE;

	`HPC_ASSERT_NEXT(a_last_resets_count, clk, arst_n, state_q == ST_FIN && sts.cur_last, count_q == 2'd0)
	`HPC_ASSERT_IMPL(a_first_edge_only_at_two, clk, arst_n, state_q == ST_SCAN && count_q != 2'd2, mask_q[1:0] == 2'b00)
	`HPC_ASSERT_IMPL(a_div_idle_outside, clk, arst_n, state_q == ST_IDLE || state_q == ST_EMIT, !sts.div_busy)

endmodule

[rtl/core/homogeneous_polygon_plane_clipper.sv]
// Top level of the homogeneous polygon plane clipper: APB plane register,
// sequencer and datapath. Depends on hpc_pkg, hpc_ctrl, hpc_datapath.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+----------------------------
//  vertex  | vtx_valid, vtx_ready, vtx            | one input vertex item
//  result  | res_valid, res_ready, res            | one clipped vertex or marker
//  config  | psel, penable, pwrite, paddr, pwdata | plane_select at address 0
//
// One vertex at a time: accept and plan, then per result slot either scan and emit to
// pass a vertex or, for a crossing, scan and divider start, the divide (no iterations
// when t is zero or saturated), 12 fields through the shared multiplier, each a multiply
// then an add, and emit; then a closing scan and an update of the held vertices.
// Reset clears the sequencer, vertex count and output valid; no clearing pass.
// A stalled result holds the sequencer in its emit or mark state; the result register
// is reloaded in the cycle it is taken.
`timescale 1ns / 1ps

module homogeneous_polygon_plane_clipper import hpc_pkg::*; #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vtx_valid,
	output logic vtx_ready,
	input  in_item_t vtx,
	output logic res_valid,
	input  logic res_ready,
	output out_item_t res,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [2:0] plane_q;
	logic cfg_wr;
	cmd_t cmd;
	sts_t sts;

	// Register 0 sits in the low word; writes to the upper word are dropped
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {29'd0, plane_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_LEFT;
		end else if (cfg_wr) begin
			plane_q <= pwdata[2:0];
		end
	end

	// Sequencer: walks the result slots of each accepted item
	hpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: held vertices, divider, lerp unit and result register
	hpc_datapath #(.T_FRAC_BITS(T_FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.plane     (plane_q),
		.vtx       (vtx),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
